@@ hw/rtl/mf5_pkg.sv @@
// Package for the five-point median filter: sample and result types,
// window and buffer sizes, and the sample-count codes.
// No dependencies.
package mf5_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int WIN_LEN      = 5;
    localparam int HIST_LEN     = 4;
    localparam int MAX_RESULTS  = 3;
    localparam int MED_RANK     = WIN_LEN / 2;

    typedef logic signed [SAMPLE_WIDTH-1:0]      sample_t;
    typedef logic [$clog2(WIN_LEN)-1:0]          rank_t;
    typedef logic [$clog2(MAX_RESULTS+1)-1:0]    res_count_t;
    typedef logic [1:0]                          seen_t;

    // samples of the current signal taken so far (two or more counts as primed)
    localparam seen_t SEEN_NONE   = 2'd0;
    localparam seen_t SEEN_ONE    = 2'd1;
    localparam seen_t SEEN_PRIMED = 2'd2;

    typedef struct packed {
        sample_t value;
        logic    last;
    } result_t;

    // result buffer status seen by the control logic
    typedef struct packed {
        res_count_t count;
        logic       load_ok;
    } rbuf_status_t;

endpackage

@@ hw/rtl/mf5_median5.sv @@
// Median of a five-sample window by a parallel rank network.
// Depends on mf5_pkg.
module mf5_median5
    import mf5_pkg::*;
(
    input  sample_t window [WIN_LEN],
    output sample_t median
);

    rank_t rank [WIN_LEN];

    // rank of each entry: entries below it, ties broken by position
    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WIN_LEN; j++)
            begin
                if (j != i)
                begin
                    if ((window[j] < window[i]) || ((j < i) && (window[j] == window[i])))
                    begin
                        rank[i] = rank[i] + rank_t'(1);
                    end
                end
            end
        end
    end

    // exactly one entry holds the middle rank
    always_comb
    begin
        median = '0;
        for (int i = 0; i < WIN_LEN; i++)
        begin
            if (rank[i] == rank_t'(MED_RANK))
            begin
                median = window[i];
            end
        end
    end

endmodule

@@ hw/rtl/mf5_result_buf.sv @@
// Result buffer: holds up to three results of one request and hands them
// out in order, one per cycle while result_ready is high. Depends on mf5_pkg.
module mf5_result_buf
    import mf5_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  res_count_t   load_count,
    input  result_t      load_items [MAX_RESULTS],
    output rbuf_status_t status,
    output logic         result_valid,
    input  logic         result_ready,
    output result_t      head
);

    res_count_t count_reg, count_next;
    result_t    slot_reg  [MAX_RESULTS];
    result_t    slot_next [MAX_RESULTS];
    logic       pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign head         = slot_reg[0];

    // a new load is taken once the buffer empties in this cycle
    assign status.load_ok = (count_reg == '0) || ((count_reg == res_count_t'(1)) && pop);
    assign status.count   = count_reg;

    // load replaces the contents, pop shifts towards the head
    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (load)
        begin
            count_next = load_count;
            slot_next  = load_items;
        end
        else if (pop)
        begin
            count_next = count_reg - res_count_t'(1);
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

@@ hw/rtl/median_filter_5.sv @@
// Top level of the streaming five-point median filter with mirrored edges.
// Depends on mf5_pkg, mf5_median5 and mf5_result_buf.
//
// One sample is taken per cycle while sample_ready is high, and its result
// appears registered on the next cycle; with result_ready high the block
// runs at one sample per cycle. The output trails the signal by two
// samples: the first two samples give no result, and the sample flagged
// end_of_signal gives up to three (its own median and two flush medians,
// the last marked last_result), handed out from a three-entry result
// buffer one per cycle while result_ready is high. A sample that ends a
// signal of two or more samples holds sample_ready low until the last of
// its results is being handed out; each cycle with result_ready low while
// a result waits stretches that stall, and stalls the input in steady flow
// too. A one-sample signal returns that sample marked last.
module median_filter_5
    import mf5_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_ready,
    input  sample_t sample,
    input  logic    end_of_signal,
    output logic    result_valid,
    input  logic    result_ready,
    output sample_t median_value,
    output logic    last_result
);

    sample_t      hist_reg  [HIST_LEN];
    sample_t      hist_next [HIST_LEN];
    sample_t      win_hist  [HIST_LEN];
    seen_t        seen_reg, seen_next;
    logic         accept;
    rbuf_status_t buf_status;
    res_count_t   load_count;
    result_t      load_items [MAX_RESULTS];
    result_t      head;
    sample_t      win_m [WIN_LEN];
    sample_t      win_a [WIN_LEN];
    sample_t      win_b [WIN_LEN];
    sample_t      med_m, med_a, med_b;

    assign sample_ready = buf_status.load_ok;
    assign accept       = sample_valid && sample_ready;

    // history after this request: mirrored head on the second sample,
    // otherwise the shifted window
    always_comb
    begin
        if (seen_reg == SEEN_ONE)
        begin
            win_hist[0] = sample;
            win_hist[1] = hist_reg[3];
            win_hist[2] = hist_reg[3];
            win_hist[3] = sample;
        end
        else
        begin
            for (int i = 0; i < HIST_LEN - 1; i++)
            begin
                win_hist[i] = hist_reg[i+1];
            end
            win_hist[HIST_LEN-1] = sample;
        end
    end

    // windows: current median, and the two mirrored tail medians
    always_comb
    begin
        for (int i = 0; i < HIST_LEN; i++)
        begin
            win_m[i] = hist_reg[i];
        end
        win_m[4] = sample;
        win_a[0] = win_hist[0];
        win_a[1] = win_hist[1];
        win_a[2] = win_hist[2];
        win_a[3] = win_hist[3];
        win_a[4] = win_hist[3];
        win_b[0] = win_hist[1];
        win_b[1] = win_hist[2];
        win_b[2] = win_hist[3];
        win_b[3] = win_hist[3];
        win_b[4] = win_hist[2];
    end

    mf5_median5 u_med_m (.window(win_m), .median(med_m));
    mf5_median5 u_med_a (.window(win_a), .median(med_a));
    mf5_median5 u_med_b (.window(win_b), .median(med_b));

    // results and next state for one request
    always_comb
    begin
        load_count = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            load_items[i] = '0;
        end
        hist_next = hist_reg;
        seen_next = seen_reg;
        case (seen_reg)
            SEEN_NONE:
            begin
                if (end_of_signal)
                begin
                    load_count    = res_count_t'(1);
                    load_items[0] = '{value: sample, last: 1'b1};
                end
                else
                begin
                    hist_next[HIST_LEN-1] = sample;
                    seen_next             = SEEN_ONE;
                end
            end
            SEEN_ONE:
            begin
                hist_next = win_hist;
                seen_next = SEEN_PRIMED;
                if (end_of_signal)
                begin
                    load_count    = res_count_t'(2);
                    load_items[0] = '{value: med_a, last: 1'b0};
                    load_items[1] = '{value: med_b, last: 1'b1};
                end
            end
            default:
            begin
                hist_next     = win_hist;
                seen_next     = SEEN_PRIMED;
                load_items[0] = '{value: med_m, last: 1'b0};
                load_count    = res_count_t'(1);
                if (end_of_signal)
                begin
                    load_count    = res_count_t'(3);
                    load_items[1] = '{value: med_a, last: 1'b0};
                    load_items[2] = '{value: med_b, last: 1'b1};
                end
            end
        endcase
        // end of signal clears the window for the next one
        if (end_of_signal)
        begin
            for (int i = 0; i < HIST_LEN; i++)
            begin
                hist_next[i] = '0;
            end
            seen_next = SEEN_NONE;
        end
    end

    // window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= SEEN_NONE;
            for (int i = 0; i < HIST_LEN; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
            hist_reg <= hist_next;
        end
    end

    mf5_result_buf u_rbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .load_count   (load_count),
        .load_items   (load_items),
        .status       (buf_status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .head         (head)
    );

    assign median_value = head.value;
    assign last_result  = head.last;

`ifndef SYNTHESIS
    // buffer never holds more than one request's results
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.count <= res_count_t'(MAX_RESULTS))
        else $error("result buffer overfilled");

    // a request ending a signal restarts the sample count
    a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_signal) |=> (seen_reg == SEEN_NONE))
        else $error("sample count not cleared after end of signal");

    // first sample of a signal alone yields no result
    a_first_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !end_of_signal && (seen_reg == SEEN_NONE)) |=> !result_valid)
        else $error("result produced for first sample");
`endif

endmodule
